// ----- src/smrp_pkg.sv -----
// Shared types and constants for the servo motion record and playback block.
package smrp_pkg;

  // Operating modes, in output code order
  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_PLAY   = 2'd2
  } mode_t;

  // Converter full scale is 2^SAMPLE_BITS - 1
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned SAMPLE_MAX  = 1023;
  localparam int unsigned ANGLE_MAX   = 180;
  localparam int unsigned ANGLE_BITS  = 8;

  // Step period after reset, in milliseconds
  localparam logic [15:0] PERIOD_RESET = 16'd100;

endpackage

// ----- src/smrp_angle.sv -----
// Converts one potentiometer sample to a servo angle, sample*180/1023 truncated.
module smrp_angle (
  input  logic [smrp_pkg::SAMPLE_BITS-1:0] sample,
  output logic [smrp_pkg::ANGLE_BITS-1:0]  angle
);

  logic [17:0] prod;
  logic [18:0] sum;
  logic [8:0]  quot;
  logic [18:0] quot_x_max;
  logic [18:0] rem;

  // Divide by 2^10-1 as (p + p/1024)/1024, then fix up by at most one
  always_comb begin
    prod       = {8'b0, sample} * 18'(smrp_pkg::ANGLE_MAX);
    sum        = {1'b0, prod} + {11'b0, prod[17:10]};
    quot       = sum[18:10];
    quot_x_max = {quot, 10'b0} - {10'b0, quot};
    rem        = {1'b0, prod} - quot_x_max;
    if (rem >= 19'(smrp_pkg::SAMPLE_MAX)) begin
      angle = smrp_pkg::ANGLE_BITS'(quot + 9'd1);
    end else begin
      angle = smrp_pkg::ANGLE_BITS'(quot);
    end
  end

endmodule

// ----- src/servo_motion_record_playback.sv -----
// Top level: mode control, angle store and result pipeline of the servo recorder.
//
//  channel | ports                        | direction | carries
//  --------+------------------------------+-----------+-------------------------------
//  in      | in_valid / in_ready          | to block  | buttons, three samples, now_ms
//  out     | out_valid / out_ready        | from block| update, angles, mode, lamps, counts
//  cfg     | cfg_valid / cfg_ready        | to block  | step period in ms (cfg_data)
//
// A request per cycle is taken unless output stalls; it passes middle and output stages.
// The angle store is a single-port synchronous RAM: a pass either writes one
// triple (record) or reads one (play), and the read data is registered as the pass enters the middle stage.
// Reset clears mode, lamps, counters and timestamp; the store is not cleared.
// A full output register stalls the middle stage; requests keep flowing while
// either stage has room.
module servo_motion_record_playback #(
  parameter int unsigned STORE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_record_button,
  input  logic        in_play_button,
  input  logic [9:0]  in_pot_a,
  input  logic [9:0]  in_pot_b,
  input  logic [9:0]  in_pot_c,
  input  logic [31:0] in_now_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_servo_update,
  output logic [7:0]  out_angle_a,
  output logic [7:0]  out_angle_b,
  output logic [7:0]  out_angle_c,
  output logic [1:0]  out_mode_now,
  output logic        out_record_lamp,
  output logic        out_play_lamp,
  output logic [7:0]  out_stored_count,
  output logic [6:0]  out_play_position,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned ENT_W = 3 * smrp_pkg::ANGLE_BITS;

  // Control state
  smrp_pkg::mode_t   mode_r, mode_nxt;
  logic              prev_rec_r, prev_rec_nxt;
  logic              prev_play_r, prev_play_nxt;
  logic              rec_led_r, rec_led_nxt;
  logic              play_led_r, play_led_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [31:0]       last_ms_r, last_ms_nxt;
  logic [15:0]       period_r;

  // Store
  logic [ENT_W-1:0]  store_mem [STORE_DEPTH];
  logic [ENT_W-1:0]  rd_data_r;
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;

  // Middle stage
  logic              s1_valid_r;
  logic              s1_update_r;
  logic              s1_read_r;
  logic [ENT_W-1:0]  s1_live_r;
  smrp_pkg::mode_t   s1_mode_r;
  logic              s1_rec_led_r, s1_play_led_r;
  logic [7:0]        s1_count_r;
  logic [6:0]        s1_pos_r;

  // Output stage
  logic              out_valid_r;
  logic              out_update_r;
  logic [ENT_W-1:0]  out_angles_r;
  smrp_pkg::mode_t   out_mode_r;
  logic              out_rec_led_r, out_play_led_r;
  logic [7:0]        out_count_r;
  logic [6:0]        out_pos_r;

  logic              in_fire, s1_adv;
  logic [7:0]        angle_a, angle_b, angle_c;
  logic [ENT_W-1:0]  live;
  logic              elapsed;
  logic              update;
  logic [31:0]       delta_ms;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W+7:0]  count_ext;
  logic [IDX_W+6:0]  pos_ext;

  smrp_angle u_angle_a (.sample(in_pot_a), .angle(angle_a));
  smrp_angle u_angle_b (.sample(in_pot_b), .angle(angle_b));
  smrp_angle u_angle_c (.sample(in_pot_c), .angle(angle_c));

  assign live = {angle_a, angle_b, angle_c};

  // Handshakes
  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_fire   = in_valid && in_ready;

  // Period check, wrapping modulo 2^32
  assign delta_ms = in_now_ms - last_ms_r;
  assign elapsed  = delta_ms >= {16'b0, period_r};

  // Next control state for an accepted request
  always_comb begin
    mode_nxt      = mode_r;
    prev_rec_nxt  = prev_rec_r;
    prev_play_nxt = prev_play_r;
    rec_led_nxt   = rec_led_r;
    play_led_nxt  = play_led_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    last_ms_nxt   = last_ms_r;
    update        = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    rd_addr       = pos_r;
    pos_inc       = CNT_W'(pos_r) + CNT_W'(1);
    if (in_fire) begin
      // record button falling edge
      if (!in_record_button && prev_rec_r) begin
        if (mode_r != smrp_pkg::MODE_RECORD) begin
          mode_nxt     = smrp_pkg::MODE_RECORD;
          count_nxt    = '0;
          rec_led_nxt  = 1'b1;
          play_led_nxt = 1'b0;
        end else begin
          mode_nxt    = smrp_pkg::MODE_MANUAL;
          rec_led_nxt = 1'b0;
        end
      end
      prev_rec_nxt = in_record_button;

      // play button falling edge, seen after the record button
      if (!in_play_button && prev_play_r) begin
        if (mode_nxt != smrp_pkg::MODE_PLAY && count_nxt != '0) begin
          mode_nxt     = smrp_pkg::MODE_PLAY;
          pos_nxt      = '0;
          play_led_nxt = 1'b1;
          rec_led_nxt  = 1'b0;
        end else begin
          mode_nxt     = smrp_pkg::MODE_MANUAL;
          play_led_nxt = 1'b0;
        end
      end
      prev_play_nxt = in_play_button;

      wr_addr = count_nxt[IDX_W-1:0];
      rd_addr = pos_nxt;
      pos_inc = CNT_W'(pos_nxt) + CNT_W'(1);

      unique case (mode_nxt)
        smrp_pkg::MODE_MANUAL: begin
          update = 1'b1;
        end
        smrp_pkg::MODE_RECORD: begin
          update = 1'b1;
          if (elapsed) begin
            if (count_nxt < CNT_W'(STORE_DEPTH)) begin
              wr_en       = 1'b1;
              count_nxt   = count_nxt + CNT_W'(1);
              last_ms_nxt = in_now_ms;
            end else begin
              mode_nxt    = smrp_pkg::MODE_MANUAL;
              rec_led_nxt = 1'b0;
            end
          end
        end
        smrp_pkg::MODE_PLAY: begin
          if (elapsed) begin
            update      = 1'b1;
            rd_en       = 1'b1;
            last_ms_nxt = in_now_ms;
            if (pos_inc >= count_nxt) begin
              pos_nxt = '0;
            end else begin
              pos_nxt = pos_inc[IDX_W-1:0];
            end
          end
        end
        default: begin
          mode_nxt = smrp_pkg::MODE_MANUAL;
        end
      endcase
    end
  end

  // Control state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= smrp_pkg::MODE_MANUAL;
      prev_rec_r  <= 1'b1;
      prev_play_r <= 1'b1;
      rec_led_r   <= 1'b0;
      play_led_r  <= 1'b0;
      count_r     <= '0;
      pos_r       <= '0;
      last_ms_r   <= '0;
      period_r    <= smrp_pkg::PERIOD_RESET;
    end else begin
      mode_r      <= mode_nxt;
      prev_rec_r  <= prev_rec_nxt;
      prev_play_r <= prev_play_nxt;
      rec_led_r   <= rec_led_nxt;
      play_led_r  <= play_led_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      last_ms_r   <= last_ms_nxt;
      if (cfg_valid && cfg_ready) begin
        period_r <= cfg_data;
      end
    end
  end

  // Angle store: one write or one registered read per pass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= live;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // Mask the counters to their field widths
  assign count_ext = {8'b0, count_nxt};
  assign pos_ext   = {7'b0, pos_nxt};

  // Middle stage: hold the pass while the store read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_update_r   <= update;
      s1_read_r     <= rd_en;
      s1_live_r     <= (update && !rd_en) ? live : '0;
      s1_mode_r     <= mode_nxt;
      s1_rec_led_r  <= rec_led_nxt;
      s1_play_led_r <= play_led_nxt;
      s1_count_r    <= count_ext[7:0];
      s1_pos_r      <= pos_ext[6:0];
    end
  end

  // Output register: take the store data for play passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_update_r   <= s1_update_r;
      out_angles_r   <= s1_read_r ? rd_data_r : s1_live_r;
      out_mode_r     <= s1_mode_r;
      out_rec_led_r  <= s1_rec_led_r;
      out_play_led_r <= s1_play_led_r;
      out_count_r    <= s1_count_r;
      out_pos_r      <= s1_pos_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_servo_update  = out_update_r;
  assign out_angle_a       = out_angles_r[23:16];
  assign out_angle_b       = out_angles_r[15:8];
  assign out_angle_c       = out_angles_r[7:0];
  assign out_mode_now      = out_mode_r;
  assign out_record_lamp   = out_rec_led_r;
  assign out_play_lamp     = out_play_led_r;
  assign out_stored_count  = out_count_r;
  assign out_play_position = out_pos_r;

  // Reads only touch entries already written
  a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (CNT_W'(rd_addr) < count_nxt))
    else $error("store read beyond recorded entries");

  // A write leaves the block recording with a nonzero count
  a_write_in_record: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (mode_r == smrp_pkg::MODE_RECORD) && (count_r != '0))
    else $error("store write outside record mode");

  // Read data must hold while its pass waits in the middle stage
  a_read_data_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> $stable(rd_data_r))
    else $error("store read data changed under a stalled pass");

  // The two lamps are never lit together
  a_lamps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(rec_led_r && play_led_r))
    else $error("record and play lamps both on");

  // Play mode always has something to play
  a_play_has_entries: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == smrp_pkg::MODE_PLAY) |-> (count_r != '0))
    else $error("play mode with empty store");

endmodule

// ----- tb/tb_servo_motion_record_playback.sv -----
// Self-checking testbench for the servo motion record and playback block.
`timescale 1ns / 1ps

module tb_servo_motion_record_playback;

  localparam int unsigned STORE_DEPTH = 128;

  typedef struct packed {
    logic        rec;
    logic        ply;
    logic [9:0]  pot_a;
    logic [9:0]  pot_b;
    logic [9:0]  pot_c;
    logic [31:0] now_ms;
  } pass_t;

  typedef struct packed {
    logic       upd;
    logic [7:0] ang_a;
    logic [7:0] ang_b;
    logic [7:0] ang_c;
    logic [1:0] mode;
    logic       rec_lamp;
    logic       ply_lamp;
    logic [7:0] count;
    logic [6:0] pos;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  pass_t       in_pass;
  logic        out_valid;
  logic        out_ready;
  logic        out_servo_update;
  logic [7:0]  out_angle_a;
  logic [7:0]  out_angle_b;
  logic [7:0]  out_angle_c;
  logic [1:0]  out_mode_now;
  logic        out_record_lamp;
  logic        out_play_lamp;
  logic [7:0]  out_stored_count;
  logic [6:0]  out_play_position;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  servo_motion_record_playback #(
    .STORE_DEPTH(STORE_DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_record_button (in_pass.rec),
    .in_play_button   (in_pass.ply),
    .in_pot_a         (in_pass.pot_a),
    .in_pot_b         (in_pass.pot_b),
    .in_pot_c         (in_pass.pot_c),
    .in_now_ms        (in_pass.now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_servo_update (out_servo_update),
    .out_angle_a      (out_angle_a),
    .out_angle_b      (out_angle_b),
    .out_angle_c      (out_angle_c),
    .out_mode_now     (out_mode_now),
    .out_record_lamp  (out_record_lamp),
    .out_play_lamp    (out_play_lamp),
    .out_stored_count (out_stored_count),
    .out_play_position(out_play_position),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // Controller copy: mode, button history, lamps, counters, store
  smrp_pkg::mode_t cur_mode = smrp_pkg::MODE_MANUAL;
  logic        rec_prev   = 1'b1;
  logic        ply_prev   = 1'b1;
  logic        rec_led    = 1'b0;
  logic        ply_led    = 1'b0;
  logic [7:0]  stored     = 8'd0;
  logic [7:0]  play_pos   = 8'd0;
  logic [31:0] last_ms    = 32'd0;
  logic [15:0] period_ms  = smrp_pkg::PERIOD_RESET;
  logic [23:0] angle_mem [0:STORE_DEPTH-1];

  pass_t       pass_q [$];
  result_t     due_results [$];
  int          pending      = 0;
  bit          in_taken     = 1'b0;
  int unsigned send_idle    = 0;
  int unsigned recv_stall   = 0;
  logic [31:0] clock_ms     = 32'd0;
  int unsigned gen_total    = 0;
  int          fail_cnt     = 0;
  int          report_cnt   = 0;
  int          checked_cnt  = 0;
  int          recorded_cnt = 0;
  int          played_cnt   = 0;
  int          full_cnt     = 0;

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [7:0] to_angle(logic [9:0] sample);
    int unsigned prod;
    prod = sample * smrp_pkg::ANGLE_MAX;
    return 8'(prod / smrp_pkg::SAMPLE_MAX);
  endfunction

  // Advance the controller by one pass and return the result it commands
  function automatic result_t step_controller(pass_t p);
    result_t     r;
    logic [7:0]  la;
    logic [7:0]  lb;
    logic [7:0]  lc;
    logic [31:0] delta;
    logic        elapsed;
    la = to_angle(p.pot_a);
    lb = to_angle(p.pot_b);
    lc = to_angle(p.pot_c);
    r  = '0;
    // record button edge first, then play button edge
    if (!p.rec && rec_prev) begin
      if (cur_mode != smrp_pkg::MODE_RECORD) begin
        cur_mode = smrp_pkg::MODE_RECORD;
        stored   = 8'd0;
        rec_led  = 1'b1;
        ply_led  = 1'b0;
      end else begin
        cur_mode = smrp_pkg::MODE_MANUAL;
        rec_led  = 1'b0;
      end
    end
    rec_prev = p.rec;
    if (!p.ply && ply_prev) begin
      if (cur_mode != smrp_pkg::MODE_PLAY && stored > 0) begin
        cur_mode = smrp_pkg::MODE_PLAY;
        play_pos = 8'd0;
        ply_led  = 1'b1;
        rec_led  = 1'b0;
      end else begin
        cur_mode = smrp_pkg::MODE_MANUAL;
        ply_led  = 1'b0;
      end
    end
    ply_prev = p.ply;
    delta   = p.now_ms - last_ms;
    elapsed = (delta >= {16'd0, period_ms});
    case (cur_mode)
      smrp_pkg::MODE_MANUAL: begin
        r.upd = 1'b1;
        {r.ang_a, r.ang_b, r.ang_c} = {la, lb, lc};
      end
      smrp_pkg::MODE_RECORD: begin
        r.upd = 1'b1;
        {r.ang_a, r.ang_b, r.ang_c} = {la, lb, lc};
        if (elapsed) begin
          if (stored < STORE_DEPTH) begin
            angle_mem[stored[6:0]] = {la, lb, lc};
            stored  = stored + 8'd1;
            last_ms = p.now_ms;
            recorded_cnt++;
          end else begin
            // store full: fall back to manual
            cur_mode = smrp_pkg::MODE_MANUAL;
            rec_led  = 1'b0;
            full_cnt++;
          end
        end
      end
      smrp_pkg::MODE_PLAY: begin
        if (elapsed) begin
          r.upd = 1'b1;
          {r.ang_a, r.ang_b, r.ang_c} = angle_mem[play_pos[6:0]];
          play_pos = play_pos + 8'd1;
          if (play_pos >= stored) play_pos = 8'd0;
          last_ms = p.now_ms;
          played_cnt++;
        end
      end
      default: ;
    endcase
    r.mode     = cur_mode;
    r.rec_lamp = rec_led;
    r.ply_lamp = ply_led;
    r.count    = stored;
    r.pos      = play_pos[6:0];
    return r;
  endfunction

  // Driver: hold a request until taken, then load the next one or idle
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pass_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_pass  <= pass_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
    in_taken = 1'b0;
  end

  // Monitor: check each accepted result, predict each accepted request
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_servo_update, out_angle_a, out_angle_b, out_angle_c, out_mode_now,
               out_record_lamp, out_play_lamp, out_stored_count, out_play_position};
        if (due_results.size() == 0) begin
          fail_cnt++;
          if (report_cnt < 10) begin
            report_cnt++;
            $display("%0t: result with nothing expected: upd=%0d ang=%0d/%0d/%0d mode=%0d",
                     $realtime, got.upd, got.ang_a, got.ang_b, got.ang_c, got.mode);
          end
        end else begin
          want = due_results.pop_front();
          checked_cnt++;
          if (got.upd !== want.upd || got.ang_a !== want.ang_a || got.ang_b !== want.ang_b ||
              got.ang_c !== want.ang_c || got.mode !== want.mode ||
              got.rec_lamp !== want.rec_lamp || got.ply_lamp !== want.ply_lamp ||
              got.count !== want.count || got.pos !== want.pos) begin
            fail_cnt++;
            if (report_cnt < 10) begin
              report_cnt++;
              $display("%0t: result %0d mismatch", $realtime, checked_cnt);
              $display("  expected upd=%0d ang=%0d/%0d/%0d mode=%0d lamps=%0d%0d cnt=%0d pos=%0d",
                       want.upd, want.ang_a, want.ang_b, want.ang_c, want.mode,
                       want.rec_lamp, want.ply_lamp, want.count, want.pos);
              $display("  actual   upd=%0d ang=%0d/%0d/%0d mode=%0d lamps=%0d%0d cnt=%0d pos=%0d",
                       got.upd, got.ang_a, got.ang_b, got.ang_c, got.mode,
                       got.rec_lamp, got.ply_lamp, got.count, got.pos);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        due_results.push_back(step_controller(in_pass));
        pending--;
        in_taken = 1'b1;
      end
    end
  end

  function automatic logic [9:0] rand_pot();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 10'd0;
    if (r < 20) return 10'd1023;
    return 10'($urandom_range(0, 1023));
  endfunction

  // Time to the next pass: mostly around the period, some at its edge, a few wild jumps
  function automatic logic [31:0] next_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(0, 2 * 32'(period_ms) + 1);
    if (r < 92) return (period_ms == 0) ? 32'd0 : 32'(period_ms) - $urandom_range(0, 1);
    return $urandom();
  endfunction

  task automatic push_pass(logic rec, logic ply, logic [9:0] pa, logic [9:0] pb,
                           logic [9:0] pc, logic [31:0] now);
    pass_t p;
    p = '{rec: rec, ply: ply, pot_a: pa, pot_b: pb, pot_c: pc, now_ms: now};
    pass_q.push_back(p);
    pending++;
    gen_total++;
    clock_ms = now;
  endtask

  task automatic emit(logic rec, logic ply, logic [31:0] gap);
    push_pass(rec, ply, rand_pot(), rand_pot(), rand_pot(), clock_ms + gap);
  endtask

  // Press one button, sometimes hold it, then release
  task automatic press(bit rec_btn);
    logic rl;
    logic pl;
    rl = rec_btn ? 1'b0 : 1'b1;
    pl = rec_btn ? 1'b1 : 1'b0;
    emit(rl, pl, next_gap());
    if ($urandom_range(3) == 0) emit(rl, pl, next_gap());
    emit(1'b1, 1'b1, next_gap());
  endtask

  // Mostly record and play sessions, with some random button noise
  task automatic gen_mix(int unsigned n);
    int unsigned stop_at;
    int unsigned r;
    int unsigned k;
    stop_at = gen_total + n;
    while (gen_total < stop_at) begin
      r = $urandom_range(99);
      if (r < 45) begin
        press(1'b1);
        k = $urandom_range(1, 30);
        repeat (k) emit(1'b1, 1'b1, next_gap());
        // leave by a second record press or straight into play
        press($urandom_range(1) == 1);
      end else if (r < 80) begin
        press(1'b0);
        k = $urandom_range(1, 30);
        repeat (k) emit(1'b1, 1'b1, next_gap());
        press(1'b0);
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) emit(1'($urandom_range(1)), 1'($urandom_range(1)), next_gap());
        emit(1'b1, 1'b1, next_gap());
      end
    end
  endtask

  task automatic write_period(logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    period_ms = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request is taken and every result has come back
  task automatic drain();
    do @(negedge clk); while (pending != 0 || due_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idling(int unsigned sender, int unsigned receiver);
    send_idle  = sender;
    recv_stall = receiver;
  endtask

  // Hard stop
  initial begin
    #10_000_000;
    $display("Timeout with %0d requests pending, %0d results due", pending, due_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_pass   = '0;
    in_pass.rec = 1'b1;
    in_pass.ply = 1'b1;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 16'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed passes at the reset period, no idling
    set_idling(0, 0);
    push_pass(1'b1, 1'b1, 10'd0, 10'd1023, 10'd512, 32'd10);     // manual, extremes
    push_pass(1'b1, 1'b0, 10'd1, 10'd1022, 10'd511, 32'd20);     // play with empty store
    push_pass(1'b1, 1'b1, 10'd1023, 10'd0, 10'd6, 32'd30);
    push_pass(1'b0, 1'b1, 10'd100, 10'd200, 10'd300, 32'd50);    // enter record, too early
    push_pass(1'b0, 1'b1, 10'd400, 10'd500, 10'd600, 32'd100);   // held, period reached
    push_pass(1'b1, 1'b1, 10'd700, 10'd800, 10'd900, 32'd199);   // one short of the period
    push_pass(1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 32'd200);
    push_pass(1'b0, 1'b1, 10'd5, 10'd6, 10'd7, 32'd230);         // stop recording
    push_pass(1'b1, 1'b0, 10'd8, 10'd9, 10'd10, 32'd400);        // start playback
    push_pass(1'b1, 1'b1, 10'd11, 10'd12, 10'd13, 32'd450);      // playback idle pass
    push_pass(1'b1, 1'b1, 10'd14, 10'd15, 10'd16, 32'd500);      // play index wraps
    push_pass(1'b1, 1'b1, 10'd17, 10'd18, 10'd19, 32'd600);
    push_pass(1'b0, 1'b0, 10'd20, 10'd21, 10'd22, 32'd650);      // both pressed together
    push_pass(1'b1, 1'b1, 10'd23, 10'd24, 10'd25, 32'd700);
    push_pass(1'b0, 1'b1, 10'd512, 10'd256, 10'd128, 32'hFFFF_FFE0); // record near wrap
    push_pass(1'b1, 1'b1, 10'd64, 10'd32, 10'd16, 32'h0000_0010);
    push_pass(1'b1, 1'b1, 10'd8, 10'd4, 10'd2, 32'h0000_0044);   // period across the wrap
    push_pass(1'b1, 1'b0, 10'd1, 10'd3, 10'd5, 32'h0000_0100);   // play straight from record
    push_pass(1'b1, 1'b1, 10'd7, 10'd9, 10'd11, 32'h0000_0101);
    push_pass(1'b1, 1'b0, 10'd13, 10'd15, 10'd17, 32'h0000_0200); // play press while playing
    push_pass(1'b1, 1'b1, 10'd1023, 10'd511, 10'd0, 32'h0000_0300);
    drain();

    // Shortest period: fill the store, then play it all the way around
    set_idling(48, 0);
    write_period(16'd1);
    press(1'b1);
    repeat (140) emit(1'b1, 1'b1, 32'($urandom_range(1, 3)));
    press(1'b0);
    repeat (140) emit(1'b1, 1'b1, 32'd1);
    press(1'b0);
    gen_mix(60);
    drain();

    // Longest period
    set_idling(0, 48);
    write_period(16'hFFFF);
    gen_mix(170);
    drain();

    // Zero period always counts as elapsed
    set_idling(15, 15);
    write_period(16'd0);
    gen_mix(150);
    drain();

    set_idling(0, 0);
    write_period(16'($urandom_range(2, 500)));
    gen_mix(150);
    drain();

    set_idling(48, 0);
    write_period(16'd250);
    gen_mix(130);
    drain();

    repeat (10) @(posedge clk);
    if (due_results.size() != 0) fail_cnt++;
    $display("Checked %0d results over %0d passes in six period settings.",
             checked_cnt, gen_total);
    $display("Triples recorded %0d, played back %0d, store filled %0d times; %0d failures.",
             recorded_cnt, played_cnt, full_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
